// ===== hw/rtl/cau_pkg.sv =====
// cau_pkg: widths, operation and status codes, shared types and the saturation helper
// for the complex arithmetic unit; no dependencies
package cau_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRAC_BITS     = 16;
  localparam int PROD_BITS     = 2 * WORD_BITS;
  // quotient bits kept by the divider: one more than a word so overflow shows
  localparam int DIV_STEPS     = WORD_BITS + 1;
  localparam int REM_SHIFT     = DIV_STEPS - FRAC_BITS;
  localparam int ROOT_BITS     = DIV_STEPS;
  localparam int ROOT_REM_BITS = ROOT_BITS + 3;
  localparam int CORE_STAGES   = DIV_STEPS + 1;

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd1;
  localparam logic [2:0] FN_MUL = 3'd2;
  localparam logic [2:0] FN_DIV = 3'd3;
  localparam logic [2:0] FN_MAG = 3'd4;
  localparam logic [2:0] FN_EQ  = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef logic [2:0]                  func_t;
  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [PROD_BITS-1:0]        wide_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    word_t val;
    logic  sat;
  } sat_word_t;

  // per-item info that rides alongside the divider and square root
  typedef struct packed {
    func_t     func;
    logic      equal;
    logic      divz;
    sat_word_t re;
    sat_word_t im;
  } side_t;

  typedef struct packed {
    side_t side;
    wide_t mag_re;
    logic  neg_re;
    wide_t mag_im;
    logic  neg_im;
    wide_t sq;
  } front_t;

  typedef struct packed {
    logic [DIV_STEPS-1:0] q;
    logic                 neg;
    logic                 ovf;
  } quot_t;

  function automatic sat_word_t clamp_word(input logic signed [PROD_BITS:0] v);
    sat_word_t r;
    logic [PROD_BITS-WORD_BITS+1:0] top;
    top = v[PROD_BITS:WORD_BITS-1];
    r.sat = !((&top) || !(|top));
    if (r.sat) begin
      r.val = v[PROD_BITS] ? WORD_MIN : WORD_MAX;
    end else begin
      r.val = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/cau_front.sv =====
// cau_front: three front stages of the complex arithmetic unit (operand register,
// products and add/sub, wide sums); depends on cau_pkg
module cau_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  cau_pkg::func_t   in_func,
  input  cau_pkg::word_t   in_a_re,
  input  cau_pkg::word_t   in_a_im,
  input  cau_pkg::word_t   in_b_re,
  input  cau_pkg::word_t   in_b_im,
  output logic             c_valid,
  output cau_pkg::front_t  c_data
);
  import cau_pkg::*;

  logic  a_valid_r;
  func_t a_func_r;
  word_t a_ar_r, a_ai_r, a_br_r, a_bi_r;

  logic      b_valid_r;
  func_t     b_func_r;
  logic      b_equal_r, b_divz_r;
  sat_word_t b_as_re_r, b_as_im_r;
  logic signed [PROD_BITS-1:0] b_prr_r, b_pii_r, b_pir_r, b_pri_r, b_pxx_r, b_pyy_r;

  logic   c_valid_r;
  front_t c_data_r;

  logic signed [WORD_BITS:0] add_re, add_im, sub_re, sub_im;
  word_t sq_x, sq_y;
  logic signed [PROD_BITS:0] mul_re_sum, mul_im_sum, num_re, num_im;
  sat_word_t mul_re, mul_im;
  front_t c_nxt;

  always_comb begin
    add_re = (WORD_BITS+1)'(a_ar_r) + (WORD_BITS+1)'(a_br_r);
    add_im = (WORD_BITS+1)'(a_ai_r) + (WORD_BITS+1)'(a_bi_r);
    sub_re = (WORD_BITS+1)'(a_ar_r) - (WORD_BITS+1)'(a_br_r);
    sub_im = (WORD_BITS+1)'(a_ai_r) - (WORD_BITS+1)'(a_bi_r);
    // the two square multipliers serve the magnitude and the divisor
    sq_x = (a_func_r == FN_MAG) ? a_ar_r : a_br_r;
    sq_y = (a_func_r == FN_MAG) ? a_ai_r : a_bi_r;
  end

  always_comb begin
    mul_re_sum = (PROD_BITS+1)'(b_prr_r) - (PROD_BITS+1)'(b_pii_r);
    mul_im_sum = (PROD_BITS+1)'(b_pir_r) + (PROD_BITS+1)'(b_pri_r);
    mul_re = clamp_word(mul_re_sum >>> FRAC_BITS);
    mul_im = clamp_word(mul_im_sum >>> FRAC_BITS);
    num_re = (PROD_BITS+1)'(b_prr_r) + (PROD_BITS+1)'(b_pii_r);
    num_im = (PROD_BITS+1)'(b_pir_r) - (PROD_BITS+1)'(b_pri_r);

    c_nxt.side.func  = b_func_r;
    c_nxt.side.equal = b_equal_r;
    c_nxt.side.divz  = b_divz_r;
    case (b_func_r) inside
      FN_ADD, FN_SUB: begin
        c_nxt.side.re = b_as_re_r;
        c_nxt.side.im = b_as_im_r;
      end
      FN_MUL: begin
        c_nxt.side.re = mul_re;
        c_nxt.side.im = mul_im;
      end
      default: begin
        c_nxt.side.re = '0;
        c_nxt.side.im = '0;
      end
    endcase
    c_nxt.neg_re = num_re[PROD_BITS];
    c_nxt.mag_re = num_re[PROD_BITS] ? PROD_BITS'(-num_re) : PROD_BITS'(num_re);
    c_nxt.neg_im = num_im[PROD_BITS];
    c_nxt.mag_im = num_im[PROD_BITS] ? PROD_BITS'(-num_im) : PROD_BITS'(num_im);
    c_nxt.sq     = PROD_BITS'($unsigned(b_pxx_r) + $unsigned(b_pyy_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_func_r  <= in_func;
      a_ar_r    <= in_a_re;
      a_ai_r    <= in_a_im;
      a_br_r    <= in_b_re;
      a_bi_r    <= in_b_im;

      b_func_r  <= a_func_r;
      b_equal_r <= (a_ar_r == a_br_r) && (a_ai_r == a_bi_r);
      b_divz_r  <= (a_func_r == FN_DIV) && (a_br_r == '0) && (a_bi_r == '0);
      b_as_re_r <= (a_func_r == FN_SUB) ? clamp_word((PROD_BITS+1)'(sub_re))
                                        : clamp_word((PROD_BITS+1)'(add_re));
      b_as_im_r <= (a_func_r == FN_SUB) ? clamp_word((PROD_BITS+1)'(sub_im))
                                        : clamp_word((PROD_BITS+1)'(add_im));
      b_prr_r   <= PROD_BITS'(a_ar_r) * PROD_BITS'(a_br_r);
      b_pii_r   <= PROD_BITS'(a_ai_r) * PROD_BITS'(a_bi_r);
      b_pir_r   <= PROD_BITS'(a_ai_r) * PROD_BITS'(a_br_r);
      b_pri_r   <= PROD_BITS'(a_ar_r) * PROD_BITS'(a_bi_r);
      b_pxx_r   <= PROD_BITS'(sq_x) * PROD_BITS'(sq_x);
      b_pyy_r   <= PROD_BITS'(sq_y) * PROD_BITS'(sq_y);

      c_data_r  <= c_nxt;
    end
  end

  assign c_valid = c_valid_r;
  assign c_data  = c_data_r;

endmodule

// ===== hw/rtl/cau_div.sv =====
// cau_div: pipelined restoring divider, one quotient bit per stage, for one part of
// the complex quotient; depends on cau_pkg
module cau_div (
  input  logic            clk,
  input  logic            en,
  input  cau_pkg::wide_t  mag,
  input  logic            neg,
  input  cau_pkg::wide_t  den,
  output cau_pkg::quot_t  quot
);
  import cau_pkg::*;

  typedef struct packed {
    wide_t                rem;
    wide_t                den;
    logic [DIV_STEPS-1:0] feed;
    logic [DIV_STEPS-1:0] q;
    logic                 neg;
    logic                 ovf;
  } dstep_t;

  dstep_t st_r   [DIV_STEPS+1];
  dstep_t st_nxt [DIV_STEPS+1];

  function automatic dstep_t div_step(input dstep_t p);
    dstep_t n;
    logic [PROD_BITS:0] trial;
    logic ge;
    trial  = {p.rem, p.feed[DIV_STEPS-1]};
    ge     = trial >= {1'b0, p.den};
    n      = p;
    n.rem  = ge ? PROD_BITS'(trial - {1'b0, p.den}) : PROD_BITS'(trial);
    n.feed = {p.feed[DIV_STEPS-2:0], 1'b0};
    n.q    = {p.q[DIV_STEPS-2:0], ge};
    return n;
  endfunction

  always_comb begin
    // quotient too wide for the kept bits when mag * 2^frac >= den * 2^steps
    st_nxt[0].ovf  = {{REM_SHIFT{1'b0}}, mag} >= {den, {REM_SHIFT{1'b0}}};
    st_nxt[0].rem  = PROD_BITS'(mag >> REM_SHIFT);
    st_nxt[0].den  = den;
    st_nxt[0].feed = {mag[REM_SHIFT-1:0], {FRAC_BITS{1'b0}}};
    st_nxt[0].q    = '0;
    st_nxt[0].neg  = neg;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      st_nxt[k] = div_step(st_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    quot.q   = st_r[DIV_STEPS].q;
    quot.neg = st_r[DIV_STEPS].neg;
    quot.ovf = st_r[DIV_STEPS].ovf;
  end

endmodule

// ===== hw/rtl/cau_sqrt.sv =====
// cau_sqrt: pipelined digit-by-digit integer square root, one root bit per stage;
// depends on cau_pkg
module cau_sqrt (
  input  logic                           clk,
  input  logic                           en,
  input  cau_pkg::wide_t                 v,
  output logic [cau_pkg::ROOT_BITS-1:0]  root
);
  import cau_pkg::*;

  typedef struct packed {
    logic [ROOT_REM_BITS-1:0] rem;
    logic [ROOT_BITS-1:0]     root;
    logic [2*ROOT_BITS-1:0]   feed;
  } sstep_t;

  sstep_t st_r   [ROOT_BITS+1];
  sstep_t st_nxt [ROOT_BITS+1];

  function automatic sstep_t sqrt_step(input sstep_t p);
    sstep_t n;
    logic [ROOT_REM_BITS-1:0] r;
    logic [ROOT_REM_BITS-1:0] trial;
    logic ge;
    r      = {p.rem[ROOT_REM_BITS-3:0], p.feed[2*ROOT_BITS-1 -: 2]};
    trial  = ROOT_REM_BITS'({p.root, 2'b01});
    ge     = r >= trial;
    n.rem  = ge ? (r - trial) : r;
    n.root = {p.root[ROOT_BITS-2:0], ge};
    n.feed = {p.feed[2*ROOT_BITS-3:0], 2'b00};
    return n;
  endfunction

  always_comb begin
    st_nxt[0].rem  = '0;
    st_nxt[0].root = '0;
    st_nxt[0].feed = (2*ROOT_BITS)'(v);
    for (int k = 1; k <= ROOT_BITS; k++) begin
      st_nxt[k] = sqrt_step(st_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign root = st_r[ROOT_BITS].root;

endmodule

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// complex_arithmetic_unit: top level, stream ports, side line and output register
// depends on cau_pkg, cau_front, cau_div, cau_sqrt
//
// Complex ALU on signed Q16.16 operands: add, subtract, multiply, divide, magnitude
// of a and an exact equality test, one result item per input item, in order. It
// takes one item per clock and holds up to 38 in flight in three front stages,
// 34 core stages and one output register. The core length is set by the two
// 33-step radix-2 restoring dividers (one per result part, one quotient bit per
// stage) and the 33-step square root that run side by side. Every operation goes
// through the full pipeline, so items leave in the order they came. A waiting
// result only stops the input when the last core stage is also full. Overflowing
// parts clamp to the word range and give status 2; a divide with b equal to zero
// gives zero parts and status 1.
module complex_arithmetic_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [4*cau_pkg::WORD_BITS-1:0]  in_tdata,   // a_re, a_im, b_re, b_im
  input  logic [2:0]                       in_tuser,   // func
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [2*cau_pkg::WORD_BITS-1:0]  out_tdata,  // res_re, res_im
  output logic [2:0]                       out_tuser   // status[1:0], equal
);
  import cau_pkg::*;

  localparam int LAST = CORE_STAGES - 1;

  // pipeline advance: free unless the last core stage is full behind a held result
  logic   en;
  logic   load;
  logic   c_valid;
  front_t c_data;

  // side line runs parallel to the divider and root stages
  logic [CORE_STAGES-1:0] sv_r;
  side_t                  side_r [CORE_STAGES];

  quot_t                quot_re, quot_im;
  logic [ROOT_BITS-1:0] root;

  // output register
  logic       out_valid_r;
  word_t      res_re_r, res_im_r;
  logic [1:0] status_r;
  logic       equal_r;

  side_t      fin;
  sat_word_t  div_re, div_im;
  logic       root_sat;
  logic       sat_any;
  word_t      res_re_nxt, res_im_nxt;
  logic [1:0] status_nxt;

  assign en        = !sv_r[LAST] || !out_valid_r || out_tready;
  assign in_tready = en;
  assign load      = out_tready || !out_valid_r;

  cau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_func  (in_tuser),
    .in_a_re  (in_tdata[WORD_BITS-1:0]),
    .in_a_im  (in_tdata[2*WORD_BITS-1:WORD_BITS]),
    .in_b_re  (in_tdata[3*WORD_BITS-1:2*WORD_BITS]),
    .in_b_im  (in_tdata[4*WORD_BITS-1:3*WORD_BITS]),
    .c_valid  (c_valid),
    .c_data   (c_data)
  );

  // both parts share the divisor |b|^2, carried in the sum of squares
  cau_div u_div_re (
    .clk  (clk),
    .en   (en),
    .mag  (c_data.mag_re),
    .neg  (c_data.neg_re),
    .den  (c_data.sq),
    .quot (quot_re)
  );

  cau_div u_div_im (
    .clk  (clk),
    .en   (en),
    .mag  (c_data.mag_im),
    .neg  (c_data.neg_im),
    .den  (c_data.sq),
    .quot (quot_im)
  );

  cau_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .v    (c_data.sq),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
    end else if (en) begin
      sv_r <= {sv_r[LAST-1:0], c_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= c_data.side;
      for (int k = 1; k < CORE_STAGES; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // signed, clamped word from the kept quotient bits
  function automatic sat_word_t div_finish(input quot_t d);
    sat_word_t r;
    logic over;
    if (d.neg) begin
      // magnitude 2^31 still fits as the most negative word
      over  = d.ovf || d.q[DIV_STEPS-1] || (d.q[WORD_BITS-1] && |d.q[WORD_BITS-2:0]);
      r.val = over ? WORD_MIN : WORD_BITS'(-d.q);
    end else begin
      over  = d.ovf || d.q[DIV_STEPS-1] || d.q[WORD_BITS-1];
      r.val = over ? WORD_MAX : WORD_BITS'(d.q);
    end
    r.sat = over;
    return r;
  endfunction

  always_comb begin
    fin        = side_r[LAST];
    div_re     = div_finish(quot_re);
    div_im     = div_finish(quot_im);
    root_sat   = |root[ROOT_BITS-1:WORD_BITS-1];
    res_re_nxt = fin.re.val;
    res_im_nxt = fin.im.val;
    sat_any    = fin.re.sat || fin.im.sat;
    case (fin.func)
      FN_DIV: begin
        if (fin.divz) begin
          // zero divisor: zero parts, no saturation
          res_re_nxt = '0;
          res_im_nxt = '0;
          sat_any    = 1'b0;
        end else begin
          res_re_nxt = div_re.val;
          res_im_nxt = div_im.val;
          sat_any    = div_re.sat || div_im.sat;
        end
      end
      FN_MAG: begin
        res_re_nxt = root_sat ? WORD_MAX : WORD_BITS'(root);
        res_im_nxt = '0;
        sat_any    = root_sat;
      end
      default: begin
      end
    endcase
    status_nxt = fin.divz ? ST_DIVZ : (sat_any ? ST_SAT : ST_OK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= sv_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (load && sv_r[LAST]) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      status_r <= status_nxt;
      equal_r  <= fin.equal;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_im_r, res_re_r};
  assign out_tuser  = {equal_r, status_r};

`ifndef SYNTHESIS
  // a held result freezes a full last core stage
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && sv_r[LAST]) |=> (sv_r[LAST] && $stable(side_r[LAST])))
    else $error("last core stage moved while the output was held");

  // input only waits when a result waits behind a full core
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_valid_r && sv_r[LAST]))
    else $error("input stalled with room in the pipeline");

  // divide by zero always reports zero parts
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_DIVZ) |-> (res_re_r == '0 && res_im_r == '0))
    else $error("divide-by-zero item with nonzero parts");
`endif

endmodule
